[hdl/tfn_pkg.sv]
// Package for the triangle face normal pipeline.
// Holds widths, stage counts and the payload structs passed between the modules.
`default_nettype none
package tfn_pkg;
  localparam int CoordWidth = 16;
  localparam int FracBits   = 14;
  localparam int EdgeWidth  = CoordWidth + 1;
  localparam int ProdWidth  = 2 * EdgeWidth;
  localparam int MagWidth   = ProdWidth;
  localparam int TopPos     = 30;
  localparam int MWidth     = TopPos + 1;
  localparam int PosWidth   = $clog2(MagWidth);
  localparam int SqWidth    = 2 * MWidth;
  localparam int SumWidth   = 64;
  localparam int RootWidth  = SumWidth / 2;
  localparam int RootSteps  = SumWidth / 2;
  localparam int QWidth     = FracBits + 1;
  localparam int NumWidth   = MWidth + FracBits + 1;
  localparam int RemWidth   = NumWidth + 1;
  localparam int OutWidth   = 16;
  localparam int InDataW    = 9 * CoordWidth;
  localparam int OutDataW   = 3 * OutWidth;

  typedef struct packed {
    logic [2:0][MagWidth-1:0] mag;
    logic [2:0]               neg;
  } xp_t;

  typedef struct packed {
    logic [2:0][MWidth-1:0] m;
    logic [2:0]             neg;
    logic                   degen;
  } side_t;
endpackage
`default_nettype wire

[hdl/triangle_face_normal_top.sv]
// Unit face normal of one triangle per transfer: cross product, scale, root, divide.
// Depends on tfn_pkg, tfn_cross, tfn_norm, tfn_sqrt and tfn_div.
//
// Takes one triangle every clock while the output is not stalled and returns its unit
// normal through 3 cross-product stages, 4 scaling stages, 32 square-root stages, 16
// divider stages and the output register; the square-root pipeline is the longest
// part. All stages advance together whenever the output register is empty
// or its transfer completes, so a stall holds every item in place.
`default_nettype none
module triangle_face_normal_top import tfn_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  // first_x, first_y, first_z, second_x .. second_z, third_x .. third_z
  input  wire logic [InDataW-1:0]  in_tdata,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  // normal_x, normal_y, normal_z
  output logic [OutDataW-1:0]      out_tdata,
  // degenerate
  output logic                     out_tuser
);
  logic                    en;
  logic                    xv, nv, sv, dv;
  xp_t                     xp;
  side_t                   nside, sside;
  logic [SumWidth-1:0]     sum;
  logic [RootWidth-1:0]    root;
  logic [2:0]              dneg;
  logic                    ddeg;
  logic [2:0][QWidth-1:0]  dq;
  logic                    out_valid_r;
  logic [OutDataW-1:0]     data_r, data_nxt;
  logic                    deg_r;
  logic [OutWidth-1:0]     mag;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  tfn_cross u_cross (
    .clk, .rst_n, .en,
    .in_valid (in_tvalid),
    .in_data  (in_tdata),
    .out_valid(xv),
    .out_xp   (xp)
  );

  tfn_norm u_norm (
    .clk, .rst_n, .en,
    .in_valid (xv),
    .in_xp    (xp),
    .out_valid(nv),
    .out_side (nside),
    .out_sum  (sum)
  );

  tfn_sqrt u_sqrt (
    .clk, .rst_n, .en,
    .in_valid (nv),
    .in_side  (nside),
    .in_sum   (sum),
    .out_valid(sv),
    .out_side (sside),
    .out_root (root)
  );

  tfn_div u_div (
    .clk, .rst_n, .en,
    .in_valid (sv),
    .in_side  (sside),
    .in_root  (root),
    .out_valid(dv),
    .out_neg  (dneg),
    .out_degen(ddeg),
    .out_q    (dq)
  );

  always_comb begin
    data_nxt = '0;
    mag      = '0;
    for (int i = 0; i < 3; i++) begin
      mag = OutWidth'(dq[i]);
      if (!ddeg) begin
        data_nxt[i*OutWidth +: OutWidth] = dneg[i] ? OutWidth'(-mag) : mag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
      deg_r  <= ddeg;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = deg_r;

`ifndef SYNTHESIS
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("degenerate result with nonzero normal");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[15:0]) <= 16384 && $signed(out_tdata[15:0]) >= -16384
                 && $signed(out_tdata[31:16]) <= 16384 && $signed(out_tdata[31:16]) >= -16384
                 && $signed(out_tdata[47:32]) <= 16384 && $signed(out_tdata[47:32]) >= -16384))
    else $error("normal component out of range");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");
`endif
endmodule
`default_nettype wire

[hdl/tfn_cross.sv]
// Edge vectors and exact cross product, three register stages.
// Depends on tfn_pkg.
`default_nettype none
module tfn_cross import tfn_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire logic [InDataW-1:0] in_data,
  output logic                    out_valid,
  output xp_t                     out_xp
);
  logic signed [EdgeWidth-1:0] e1_r [3];
  logic signed [EdgeWidth-1:0] e2_r [3];
  logic signed [ProdWidth-1:0] p_r  [6];
  logic signed [ProdWidth-1:0] p_nxt[6];
  logic signed [ProdWidth:0]   c    [3];
  xp_t                         xp_r, xp_nxt;
  logic [2:0]                  v_r;

  always_comb begin
    p_nxt[0] = e1_r[1] * e2_r[2];
    p_nxt[1] = e1_r[2] * e2_r[1];
    p_nxt[2] = e1_r[2] * e2_r[0];
    p_nxt[3] = e1_r[0] * e2_r[2];
    p_nxt[4] = e1_r[0] * e2_r[1];
    p_nxt[5] = e1_r[1] * e2_r[0];
    for (int i = 0; i < 3; i++) begin
      c[i] = {p_r[2*i][ProdWidth-1], p_r[2*i]} - {p_r[2*i+1][ProdWidth-1], p_r[2*i+1]};
      xp_nxt.neg[i] = c[i][ProdWidth];
      xp_nxt.mag[i] = c[i][ProdWidth] ? MagWidth'(-c[i]) : MagWidth'(c[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1_r[i] <= $signed({in_data[(3+i)*CoordWidth+CoordWidth-1],
                            in_data[(3+i)*CoordWidth +: CoordWidth]})
                 - $signed({in_data[i*CoordWidth+CoordWidth-1],
                            in_data[i*CoordWidth +: CoordWidth]});
        e2_r[i] <= $signed({in_data[(6+i)*CoordWidth+CoordWidth-1],
                            in_data[(6+i)*CoordWidth +: CoordWidth]})
                 - $signed({in_data[i*CoordWidth+CoordWidth-1],
                            in_data[i*CoordWidth +: CoordWidth]});
      end
      for (int i = 0; i < 6; i++) begin
        p_r[i] <= p_nxt[i];
      end
      xp_r <= xp_nxt;
    end
  end

  assign out_valid = v_r[2];
  assign out_xp    = xp_r;
endmodule
`default_nettype wire

[hdl/tfn_norm.sv]
// Block-floating scale of the cross product and sum of squares, four stages.
// Depends on tfn_pkg.
`default_nettype none
module tfn_norm import tfn_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire xp_t           in_xp,
  output logic               out_valid,
  output side_t              out_side,
  output logic [SumWidth-1:0] out_sum
);
  logic [MagWidth-1:0] any;
  logic [PosWidth-1:0] tb_nxt, tb_r;
  xp_t                 xp_r;
  logic                degen_r;
  side_t               s5_r, s6_r, s7_r;
  side_t               s5_nxt;
  logic [SqWidth-1:0]  sq_r [3];
  logic [SumWidth-1:0] sum_r;
  logic [3:0]          v_r;
  logic [63:0]         wide;

  always_comb begin
    any    = in_xp.mag[0] | in_xp.mag[1] | in_xp.mag[2];
    tb_nxt = '0;
    for (int i = 0; i < MagWidth; i++) begin
      if (any[i]) tb_nxt = PosWidth'(i);
    end
  end

  always_comb begin
    s5_nxt.neg   = xp_r.neg;
    s5_nxt.degen = degen_r;
    wide = '0;
    for (int i = 0; i < 3; i++) begin
      if (tb_r >= PosWidth'(TopPos)) begin
        wide = 64'(xp_r.mag[i]) >> (tb_r - PosWidth'(TopPos));
      end else begin
        wide = 64'(xp_r.mag[i]) << (PosWidth'(TopPos) - tb_r);
      end
      s5_nxt.m[i] = wide[MWidth-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tb_r    <= tb_nxt;
      xp_r    <= in_xp;
      degen_r <= (any == '0);
      s5_r    <= s5_nxt;
      s6_r    <= s5_r;
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= s5_r.m[i] * s5_r.m[i];
      end
      s7_r  <= s6_r;
      sum_r <= SumWidth'(sq_r[0]) + SumWidth'(sq_r[1]) + SumWidth'(sq_r[2]);
    end
  end

  assign out_valid = v_r[3];
  assign out_side  = s7_r;
  assign out_sum   = sum_r;
endmodule
`default_nettype wire

[hdl/tfn_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
// Depends on tfn_pkg.
`default_nettype none
module tfn_sqrt import tfn_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire side_t                in_side,
  input  wire logic [SumWidth-1:0]  in_sum,
  output logic                      out_valid,
  output side_t                     out_side,
  output logic [RootWidth-1:0]      out_root
);
  logic [SumWidth-1:0]  n_r   [RootSteps];
  logic [SumWidth-1:0]  res_r [RootSteps];
  side_t                sd_r  [RootSteps];
  logic [RootSteps-1:0] v_r;

  for (genvar i = 0; i < RootSteps; i++) begin : g_step
    localparam logic [SumWidth-1:0] Bit = SumWidth'(1) << (SumWidth - 2 - 2 * i);
    logic [SumWidth-1:0] n_in;
    logic [SumWidth-1:0] res_in;
    side_t               sd_in;
    logic                v_in;
    logic [SumWidth-1:0] trial;

    if (i == 0) begin : g_head
      assign n_in   = in_sum;
      assign res_in = '0;
      assign sd_in  = in_side;
      assign v_in   = in_valid;
    end else begin : g_body
      assign n_in   = n_r[i-1];
      assign res_in = res_r[i-1];
      assign sd_in  = sd_r[i-1];
      assign v_in   = v_r[i-1];
    end

    assign trial = res_in + Bit;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd_r[i] <= sd_in;
        if (n_in >= trial) begin
          n_r[i]   <= n_in - trial;
          res_r[i] <= (res_in >> 1) + Bit;
        end else begin
          n_r[i]   <= n_in;
          res_r[i] <= res_in >> 1;
        end
      end
    end
  end

  assign out_valid = v_r[RootSteps-1];
  assign out_side  = sd_r[RootSteps-1];
  assign out_root  = res_r[RootSteps-1][RootWidth-1:0];
endmodule
`default_nettype wire

[hdl/tfn_div.sv]
// Three-lane pipelined restoring divider: an input stage, then one quotient bit per stage.
// Depends on tfn_pkg.
`default_nettype none
module tfn_div import tfn_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire side_t                in_side,
  input  wire logic [RootWidth-1:0] in_root,
  output logic                      out_valid,
  output logic [2:0]                out_neg,
  output logic                      out_degen,
  output logic [2:0][QWidth-1:0]    out_q
);
  logic [RootWidth-1:0]         r_r   [QWidth+1];
  logic [2:0][RemWidth-1:0]     rem_r [QWidth+1];
  logic [2:0][QWidth-1:0]       q_r   [QWidth+1];
  logic [2:0]                   neg_r [QWidth+1];
  logic                         dg_r  [QWidth+1];
  logic [QWidth:0]              v_r;
  logic [RootWidth-1:0]         rdiv;

  assign rdiv = in_root | RootWidth'(in_root == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0]   <= rdiv;
      neg_r[0] <= in_side.neg;
      dg_r[0]  <= in_side.degen;
      q_r[0]   <= '0;
      for (int i = 0; i < 3; i++) begin
        rem_r[0][i] <= RemWidth'({in_side.m[i], FracBits'(0)}) + RemWidth'(rdiv >> 1);
      end
    end
  end

  for (genvar k = 0; k < QWidth; k++) begin : g_step
    localparam int Sh = QWidth - 1 - k;
    logic [RemWidth-1:0] d;
    assign d = RemWidth'(r_r[k]) << Sh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[k+1]   <= r_r[k];
        neg_r[k+1] <= neg_r[k];
        dg_r[k+1]  <= dg_r[k];
        for (int i = 0; i < 3; i++) begin
          if (rem_r[k][i] >= d) begin
            rem_r[k+1][i] <= rem_r[k][i] - d;
            q_r[k+1][i]   <= q_r[k][i] | (QWidth'(1) << Sh);
          end else begin
            rem_r[k+1][i] <= rem_r[k][i];
            q_r[k+1][i]   <= q_r[k][i];
          end
        end
      end
    end
  end

  assign out_valid = v_r[QWidth];
  assign out_neg   = neg_r[QWidth];
  assign out_degen = dg_r[QWidth];
  assign out_q     = q_r[QWidth];
endmodule
`default_nettype wire
